// ===== design/stc_pkg.sv =====
package stc_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DECIDED   = 2'd0,
    ST_NOT_SLICE = 2'd1,
    ST_PARSE_ERR = 2'd2,
    ST_TRUNC     = 2'd3
  } status_e;

  // Parser phase
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_ZEROS = 2'd1,
    PH_INFO  = 2'd2,
    PH_DONE  = 2'd3
  } phase_e;

  // NAL unit types of interest
  localparam logic [4:0] NAL_NON_IDR = 5'd1;
  localparam logic [4:0] NAL_IDR     = 5'd5;
  localparam logic [4:0] NAL_SPS     = 5'd7;

  // Slice type limits and classes
  localparam logic [3:0] SLICE_TYPE_MAX = 4'd9;
  localparam logic [3:0] SLICE_TYPE_I   = 4'd2;
  localparam logic [3:0] SLICE_TYPE_I7  = 4'd7;
  localparam logic [2:0] CLASS_I        = 3'd2;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       first_byte;
    logic       last_byte;
  } in_req_t;

  typedef struct packed {
    status_e    status;
    logic [2:0] slice_class;
    logic       intra_sync;
  } out_req_t;

  // slice_type mod 5 for slice types 0..9
  function automatic logic [2:0] slice_class_f(input logic [3:0] st);
    logic [2:0] cls;
    case (st)
      4'd0, 4'd5: cls = 3'd0;
      4'd1, 4'd6: cls = 3'd1;
      4'd2, 4'd7: cls = 3'd2;
      4'd3, 4'd8: cls = 3'd3;
      4'd4, 4'd9: cls = 3'd4;
      default:    cls = 3'd0;
    endcase
    return cls;
  endfunction

endpackage

// ===== design/stc_if.sv =====
// Byte request channel
interface stc_in_if;
  import stc_pkg::*;
  logic    valid;
  logic    ready;
  in_req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Result request channel
interface stc_out_if;
  import stc_pkg::*;
  logic     valid;
  logic     ready;
  out_req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Mode register write channel
interface stc_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/h264_slice_type_classifier_unit.sv =====
// H.264 slice type classifier.
// in_ch carries the bytes of one NAL unit, header byte first (first_byte set),
// last_byte on the final byte; start codes are already stripped. For slice
// units the first_mb_in_slice and slice_type exp-Golomb codes are parsed (in
// check mode, non-IDR units only) and one result request per unit goes out on
// out_ch: status, slice_type mod 5 and the intra sync flag. Bytes outside a
// unit, and bytes after the decision, produce nothing. cfg_ch writes the 1-bit
// check mode (0 classify, 1 intra sync check); it is always ready, and the
// user must write it only while the block is idle; the block does not enforce
// this. Throughput: one byte per cycle while out_ch does not stall. A byte is
// captured in an input register, then all eight bits are parsed together into
// the result register, which drives out_ch. When out_ch stalls, the result
// register holds its request and the input register absorbs one more byte;
// in_ch.ready drops only when both are full. Reset (rst_ni low) returns the
// parser to idle, clears the mode to classify and empties both registers.
module h264_slice_type_classifier_unit #(
  parameter int MAX_HEADER_BITS = 48
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  stc_in_if.sink    in_ch,
  stc_out_if.source out_ch,
  stc_cfg_if.sink   cfg_ch
);
  import stc_pkg::*;

  localparam int BU_W = $clog2(MAX_HEADER_BITS + 2);
  localparam logic [BU_W-1:0] MAX_BU  = BU_W'(MAX_HEADER_BITS);
  localparam logic [BU_W-1:0] ONE_BU  = BU_W'(1);
  localparam logic [BU_W-1:0] ZR_LONG = BU_W'(3);

  // Mode register
  logic check_mode_q;

  // Input stage
  logic    in_vld_q;
  in_req_t in_q;

  // Parser state
  phase_e          phase_q, phase_d;
  logic [4:0]      unit_q, unit_d;
  logic [BU_W-1:0] bits_q, bits_d;
  logic            code_q, code_d;
  logic [BU_W-1:0] zrun_q, zrun_d;
  logic [BU_W-1:0] left_q, left_d;
  logic [2:0]      info_q, info_d;

  // Result stage
  logic     out_vld_q;
  out_req_t out_q;

  logic     proc_go;
  logic     res_hit;
  out_req_t res;

  assign proc_go      = in_vld_q && (!out_vld_q || out_ch.ready);
  assign in_ch.ready  = !in_vld_q || proc_go;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_vld_q;
  assign out_ch.data  = out_q;

  // Byte parse: header decision or eight exp-Golomb bit steps
  always_comb begin
    logic            b;
    logic            fin;
    logic [3:0]      val;
    phase_e          ph;
    logic [4:0]      ut;
    logic [BU_W-1:0] bu;
    logic            ci;
    logic [BU_W-1:0] zr;
    logic [BU_W-1:0] il;
    logic [2:0]      iv;

    ph = phase_q;
    ut = unit_q;
    bu = bits_q;
    ci = code_q;
    zr = zrun_q;
    il = left_q;
    iv = info_q;
    b  = 1'b0;
    fin = 1'b0;
    val = '0;
    res_hit = 1'b0;
    res.status      = ST_DECIDED;
    res.slice_class = '0;
    res.intra_sync  = 1'b0;

    if (in_q.first_byte) begin
      ut = in_q.byte_value[4:0];
      bu = '0;
      ci = 1'b0;
      zr = '0;
      il = '0;
      iv = '0;
      ph = PH_ZEROS;
      if (!check_mode_q) begin
        if (ut < NAL_NON_IDR || ut > NAL_IDR) begin
          res_hit = 1'b1;
          res.status = ST_NOT_SLICE;
        end
      end else if (ut == NAL_IDR || ut == NAL_SPS) begin
        res_hit = 1'b1;
        res.intra_sync = 1'b1;
      end else if (ut != NAL_NON_IDR) begin
        res_hit = 1'b1;
        res.status = ST_NOT_SLICE;
      end
    end else begin
      for (int i = 7; i >= 0; i--) begin
        if (!res_hit && (ph == PH_ZEROS || ph == PH_INFO)) begin
          fin = 1'b0;
          b   = in_q.byte_value[i];
          bu  = bu + ONE_BU;
          if (ph == PH_ZEROS) begin
            if (!b) begin
              zr = zr + ONE_BU;
              if (bu > MAX_BU) begin
                res_hit = 1'b1;
                res.status = ST_PARSE_ERR;
              end
            end else if (({1'b0, bu} + {1'b0, zr}) > {1'b0, MAX_BU}) begin
              // code would end past the header bit limit
              res_hit = 1'b1;
              res.status = ST_PARSE_ERR;
            end else begin
              iv = '0;
              if (zr == '0) begin
                fin = 1'b1;
              end else begin
                il = zr;
                ph = PH_INFO;
              end
            end
          end else begin
            iv = {iv[1:0], b};
            il = il - ONE_BU;
            if (il == '0) begin
              fin = 1'b1;
            end
          end
          // code complete
          if (fin) begin
            if (!ci) begin
              ci = 1'b1;
              zr = '0;
              iv = '0;
              il = '0;
              ph = PH_ZEROS;
            end else begin
              res_hit = 1'b1;
              val = 4'((4'd1 << zr[1:0]) - 4'd1) + {1'b0, iv};
              if (zr > ZR_LONG || val > SLICE_TYPE_MAX) begin
                res.status = ST_PARSE_ERR;
              end else if (!check_mode_q) begin
                res.slice_class = slice_class_f(val);
                res.intra_sync  = (slice_class_f(val) == CLASS_I);
              end else if (ut == NAL_IDR) begin
                res.slice_class = slice_class_f(val);
                res.intra_sync  = 1'b1;
              end else if (ut == NAL_NON_IDR) begin
                res.slice_class = slice_class_f(val);
                res.intra_sync  = (val == SLICE_TYPE_I || val == SLICE_TYPE_I7);
              end else begin
                res.status = ST_NOT_SLICE;
              end
            end
          end
        end
      end
    end

    // unit ended before a decision
    if (!res_hit && in_q.last_byte && (ph == PH_ZEROS || ph == PH_INFO)) begin
      res_hit = 1'b1;
      res.status = ST_TRUNC;
    end

    if (res_hit) begin
      ph = PH_DONE;
    end

    phase_d = ph;
    unit_d  = ut;
    bits_d  = bu;
    code_d  = ci;
    zrun_d  = zr;
    left_d  = il;
    info_d  = iv;
  end

  // Mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      check_mode_q <= 1'b0;
    end else if (cfg_ch.valid) begin
      check_mode_q <= cfg_ch.data;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      in_q <= in_ch.data;
    end
  end

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      unit_q  <= '0;
      bits_q  <= '0;
      code_q  <= 1'b0;
      zrun_q  <= '0;
      left_q  <= '0;
      info_q  <= '0;
    end else if (proc_go) begin
      phase_q <= phase_d;
      unit_q  <= unit_d;
      bits_q  <= bits_d;
      code_q  <= code_d;
      zrun_q  <= zrun_d;
      left_q  <= left_d;
      info_q  <= info_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (proc_go && res_hit) begin
      out_vld_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_go && res_hit) begin
      out_q <= res;
    end
  end

  // A result always leaves the parser finished with the unit
  a_done_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_go && res_hit |=> phase_q == PH_DONE)
    else $error("parser not done after result");

  // Info bits are only read inside the header bit limit
  a_info_in_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_INFO |-> bits_q <= MAX_BU && left_q != '0)
    else $error("info phase outside limit");

  // Only a decided result carries a class or a sync flag
  a_undecided_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.status != ST_DECIDED |-> out_q.slice_class == '0 && !out_q.intra_sync)
    else $error("undecided result with class or sync");

endmodule
